// ===== rtl/core/srr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srr_pkg
// Shared types and constants of the selective-repeat receiver: header and
// result transfer structs, result kinds, controller states and the command
// and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package srr_pkg;

    localparam int WINDOW     = 16;
    localparam int SLOT_W     = $clog2(WINDOW);
    localparam int NUM_DWORDS = 5;
    localparam int DWORD_W    = $clog2(NUM_DWORDS);

    localparam logic [DWORD_W-1:0] LAST_DWORD = DWORD_W'(NUM_DWORDS - 1);
    localparam logic [8:0]         HDR_BYTES  = 9'd20;
    localparam logic [15:0]        CSUM_GOOD  = 16'hFFFF;
    localparam int                 FIN_BIT    = 8;
    localparam int                 SYN_BIT    = 9;

    typedef enum logic [1:0] {
        KIND_SYNACK  = 2'd0,
        KIND_ACK     = 2'd1,
        KIND_DELIVER = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_CHECK,
        ST_DELIVER
    } t_state;

    typedef struct packed {
        logic [31:0] hdr_ports;
        logic [31:0] hdr_seq;
        logic [31:0] hdr_ack;
        logic [31:0] hdr_ctrl;
        logic [31:0] hdr_length;
    } t_hdr;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] seq_value;
        logic        fin_flag;
        logic [8:0]  data_offset;
        logic [15:0] data_length;
        logic        last;
    } t_res;

    typedef struct packed {
        logic load;
        logic sum;
        logic decide;
        logic deliver;
    } t_cmd;

    typedef struct packed {
        logic sum_done;
        logic release_now;
        logic next_ready;
    } t_stat;

endpackage : srr_pkg
`default_nettype wire

// ===== rtl/core/srr_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srr_ctrl
// Controller of the receiver: sequences checksum, decision and in-order
// release steps and issues at most one command per cycle to the datapath.
// ----------------------------------------------------------------------------
module srr_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire srr_pkg::t_stat i_stat,
    output srr_pkg::t_cmd       o_cmd
);
    import srr_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                if (i_stat.sum_done) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = i_stat.release_now ? ST_DELIVER : ST_IDLE;
            end
            ST_DELIVER: begin
                n_state = i_stat.next_ready ? ST_DELIVER : ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
            end
            ST_CHECK: begin
                o_cmd.decide = 1'b1;
            end
            ST_DELIVER: begin
                o_cmd.deliver = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

endmodule : srr_ctrl
`default_nettype wire

// ===== rtl/core/srr_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srr_datapath
// Datapath of the receiver: header register, one's-complement checksum
// accumulator, window base and slot records, and the result register.
// ----------------------------------------------------------------------------
module srr_datapath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire srr_pkg::t_hdr i_hdr,
    input  wire srr_pkg::t_cmd i_cmd,
    output srr_pkg::t_stat     o_stat,
    output logic               o_valid,
    output srr_pkg::t_res      o_res
);
    import srr_pkg::*;

    t_hdr               r_hdr;
    logic [15:0]        r_acc;
    logic [DWORD_W-1:0] r_idx;
    logic [15:0]        r_base;
    logic [SLOT_W-1:0]  r_base_slot;
    logic [WINDOW-1:0]  r_received;
    logic               r_fin  [WINDOW];
    logic [15:0]        r_len  [WINDOW];
    logic [7:0]         r_name [WINDOW];
    logic               r_valid;
    t_res               r_res;

    logic [31:0]       dword;
    logic [16:0]       add_lo;
    logic [15:0]       fold_lo;
    logic [16:0]       add_hi;
    logic [15:0]       n_acc;
    logic [15:0]       seq;
    logic [15:0]       seq_gap;
    logic              hdr_ok;
    logic              is_syn;
    logic              is_fin;
    logic              in_window;
    logic              behind;
    logic [SLOT_W:0]   slot_sum;
    logic [SLOT_W-1:0] slot;
    logic              base_ready;
    logic [SLOT_W-1:0] next_slot;
    logic              next_ready;
    logic [8:0]        dlv_offset;
    logic              n_valid;
    t_res              n_res;

    // checksum: two halfwords per cycle, end-around carry after each add
    always_comb begin
        case (r_idx)
            DWORD_W'(0): dword = r_hdr.hdr_ports;
            DWORD_W'(1): dword = r_hdr.hdr_seq;
            DWORD_W'(2): dword = r_hdr.hdr_ack;
            DWORD_W'(3): dword = r_hdr.hdr_ctrl;
            DWORD_W'(4): dword = r_hdr.hdr_length;
            default:     dword = '0;
        endcase
        add_lo  = {1'b0, r_acc} + {1'b0, dword[15:0]};
        fold_lo = add_lo[16] ? (add_lo[15:0] + 16'd1) : add_lo[15:0];
        add_hi  = {1'b0, fold_lo} + {1'b0, dword[31:16]};
        n_acc   = add_hi[16] ? (add_hi[15:0] + 16'd1) : add_hi[15:0];
    end

    // window decision and slot of the arriving sequence (seq mod WINDOW)
    always_comb begin
        seq       = r_hdr.hdr_seq[15:0];
        is_fin    = r_hdr.hdr_ctrl[FIN_BIT];
        is_syn    = r_hdr.hdr_ctrl[SYN_BIT];
        hdr_ok    = (r_acc == CSUM_GOOD);
        seq_gap   = seq - r_base;
        in_window = (seq_gap < 16'(WINDOW));
        behind    = seq_gap[15];
        slot_sum  = {1'b0, r_base_slot} + {1'b0, seq_gap[SLOT_W-1:0]};
        if (seq < r_base) begin
            slot = seq[SLOT_W-1:0];
        end else if (slot_sum >= (SLOT_W + 1)'(WINDOW)) begin
            slot = SLOT_W'(slot_sum - (SLOT_W + 1)'(WINDOW));
        end else begin
            slot = slot_sum[SLOT_W-1:0];
        end
        base_ready = r_received[r_base_slot] || (slot == r_base_slot);
        if (r_base == 16'hFFFF || r_base_slot == SLOT_W'(WINDOW - 1)) begin
            next_slot = '0;
        end else begin
            next_slot = r_base_slot + SLOT_W'(1);
        end
        next_ready = r_received[next_slot] && (next_slot != r_base_slot);
        dlv_offset = HDR_BYTES + ((r_base == 16'd0) ? {1'b0, r_name[r_base_slot]} : 9'd0);
    end

    always_comb begin
        o_stat.sum_done    = (r_idx == LAST_DWORD);
        o_stat.release_now = hdr_ok && !is_syn && in_window && base_ready;
        o_stat.next_ready  = next_ready;
    end

    always_comb begin
        n_valid           = 1'b0;
        n_res.kind        = KIND_ACK;
        n_res.seq_value   = seq;
        n_res.fin_flag    = is_fin;
        n_res.data_offset = HDR_BYTES;
        n_res.data_length = 16'd0;
        n_res.last        = 1'b1;
        if (i_cmd.decide && hdr_ok) begin
            if (is_syn) begin
                n_valid         = 1'b1;
                n_res.kind      = KIND_SYNACK;
                n_res.seq_value = 16'd0;
                n_res.fin_flag  = 1'b0;
            end else if (in_window) begin
                n_valid    = 1'b1;
                n_res.last = !base_ready;
            end else if (behind) begin
                n_valid = 1'b1;
            end
        end else if (i_cmd.deliver) begin
            n_valid           = 1'b1;
            n_res.kind        = KIND_DELIVER;
            n_res.seq_value   = r_base;
            n_res.fin_flag    = r_fin[r_base_slot];
            n_res.data_offset = dlv_offset;
            n_res.data_length = r_len[r_base_slot];
            n_res.last        = !next_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_hdr <= i_hdr;
            r_acc <= '0;
        end else if (i_cmd.sum) begin
            r_acc <= n_acc;
        end
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.load) begin
            r_idx <= '0;
        end else if (i_cmd.sum) begin
            r_idx <= r_idx + DWORD_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_base_slot <= '0;
            r_received  <= '0;
            r_valid     <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (i_cmd.decide && hdr_ok && is_syn) begin
                r_base      <= '0;
                r_base_slot <= '0;
                r_received  <= '0;
            end else if (i_cmd.decide && hdr_ok && in_window) begin
                r_received[slot] <= 1'b1;
            end else if (i_cmd.deliver) begin
                r_received[r_base_slot] <= 1'b0;
                r_base      <= r_base + 16'd1;
                r_base_slot <= next_slot;
            end
        end
    end

    // record slot only on first arrival; duplicates keep the old record
    always_ff @(posedge i_clk) begin
        if (i_cmd.decide && hdr_ok && !is_syn && in_window && !r_received[slot]) begin
            r_fin[slot]  <= is_fin;
            r_len[slot]  <= r_hdr.hdr_length[15:0];
            r_name[slot] <= r_hdr.hdr_ctrl[7:0];
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

`ifndef NO_ASSERTIONS
    a_synack_resets_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_res.kind == KIND_SYNACK) |-> (r_base == 16'd0 && r_res.last))
        else $error("SYN-ACK transfer without cleared window base");

    a_deliver_advances_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_res.kind == KIND_DELIVER) |-> (r_res.seq_value == r_base - 16'd1))
        else $error("delivered sequence does not trail window base");

    a_deliver_from_marked_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.deliver |-> r_received[r_base_slot])
        else $error("release of an unmarked slot");

    a_burst_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_res.last) |=> r_valid)
        else $error("result burst ended without last");
`endif

endmodule : srr_datapath
`default_nettype wire

// ===== rtl/core/selective_repeat_receiver.sv =====
`default_nettype none
// Sequence: one checksum step per header dword (five dwords), then a decision
//   step; the first result is registered from the decision step.
// Flow: busy stays high through the checksum and decision steps and through a
//   delivery step for each in-order release; a new header is taken only while
//   busy is low. Results are single-cycle strobes, never stalled.
// Reset: synchronous, active low; clears window base and all slot marks.
// ----------------------------------------------------------------------------
// selective_repeat_receiver
// Header path of a selective-repeat ARQ receiver: checksum verify, window
// tracking, ACK and SYN-ACK replies, and in-order release of slots.
// ----------------------------------------------------------------------------
module selective_repeat_receiver (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire srr_pkg::t_hdr i_hdr,
    output logic               o_valid,
    output srr_pkg::t_res      o_res
);
    import srr_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    srr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    srr_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hdr   (i_hdr),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

endmodule : selective_repeat_receiver
`default_nettype wire

// ===== tb/sv/tb_selective_repeat_receiver.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_selective_repeat_receiver
// Self-checking bench for the selective-repeat receiver header path. A short
// table of directed headers is sent first: checksum failures, SYN, a filled
// window released in one go, and the window edges. Randomly built segments
// follow, mostly well-formed and close to the window. Every header taken by
// the block runs through a local window model; its predicted replies, or a
// row's typed replies, are queued and matched in order to result strobes.
// ----------------------------------------------------------------------------
module tb_selective_repeat_receiver;
    import srr_pkg::*;

    localparam int RAND_ITEMS = 285;
    localparam int SETTLE     = 20;

    typedef struct {
        t_hdr hdr;
        int   n_typed;
        t_res want0;
        t_res want1;
    } t_stim_row;

    logic  i_clk   = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start   = 1'b0;
    t_hdr  i_hdr   = '0;
    logic  busy;
    logic  o_valid;
    t_res  o_res;

    logic [15:0] win_base;
    logic        slot_held     [WINDOW];
    logic        held_fin      [WINDOW];
    logic [15:0] held_len      [WINDOW];
    logic [7:0]  held_name_len [WINDOW];

    t_res      new_replies[$];
    t_res      pending_replies[$];
    t_stim_row stim_table[$];
    int        fail_count = 0;
    int        burst_left = 0;

    selective_repeat_receiver dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_hdr   (i_hdr),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("** selective_repeat_receiver: FAILED **");
        $finish;
    end

    function automatic logic [15:0] hdr_sum(t_hdr h);
        logic [159:0] flat;
        logic [31:0]  dw;
        logic [16:0]  acc;
        acc  = '0;
        flat = h;
        for (int w = 0; w < NUM_DWORDS; w++) begin
            dw = flat[159 - 32*w -: 32];
            for (int hw = 0; hw < 2; hw++) begin
                acc = {1'b0, acc[15:0]} + {1'b0, (hw == 0) ? dw[15:0] : dw[31:16]};
                if (acc[16]) begin
                    acc = {1'b0, acc[15:0]} + 17'd1;
                end
            end
        end
        return acc[15:0];
    endfunction

    function automatic t_hdr seal_hdr(t_hdr h);
        h.hdr_ctrl[31:16] = '0;
        h.hdr_ctrl[31:16] = ~hdr_sum(h);
        return h;
    endfunction

    function automatic t_hdr segment_hdr(logic [15:0] sq, logic [7:0] nlen, logic fn,
                                         logic syn, logic [15:0] len);
        t_hdr h;
        h.hdr_ports           = $urandom;
        h.hdr_seq             = $urandom;
        h.hdr_seq[15:0]       = sq;
        h.hdr_ack             = $urandom;
        h.hdr_ctrl            = $urandom;
        h.hdr_ctrl[7:0]       = nlen;
        h.hdr_ctrl[FIN_BIT]   = fn;
        h.hdr_ctrl[SYN_BIT]   = syn;
        h.hdr_length          = $urandom;
        h.hdr_length[15:0]    = len;
        return seal_hdr(h);
    endfunction

    function automatic t_res mk_reply(t_kind k, logic [15:0] sq, logic fn,
                                      logic [8:0] off, logic [15:0] len, logic lst);
        t_res r;
        r.kind        = k;
        r.seq_value   = sq;
        r.fin_flag    = fn;
        r.data_offset = off;
        r.data_length = len;
        r.last        = lst;
        return r;
    endfunction

    task automatic predict_replies(input t_hdr h);
        logic [15:0]       sq;
        logic [15:0]       seq_gap;
        logic              fn;
        logic [SLOT_W-1:0] s;
        logic [8:0]        off;
        int                k;
        new_replies.delete();
        sq = h.hdr_seq[15:0];
        fn = h.hdr_ctrl[FIN_BIT];
        if (hdr_sum(h) != CSUM_GOOD) return;
        if (h.hdr_ctrl[SYN_BIT]) begin
            win_base = '0;
            for (k = 0; k < WINDOW; k++) slot_held[k] = 1'b0;
            new_replies.push_back(mk_reply(KIND_SYNACK, 16'd0, 1'b0, HDR_BYTES, 16'd0, 1'b1));
            return;
        end
        seq_gap = sq - win_base;
        if (seq_gap < WINDOW) begin
            s = sq[SLOT_W-1:0];
            if (!slot_held[s]) begin
                slot_held[s]     = 1'b1;
                held_fin[s]      = fn;
                held_len[s]      = h.hdr_length[15:0];
                held_name_len[s] = h.hdr_ctrl[7:0];
            end
            new_replies.push_back(mk_reply(KIND_ACK, sq, fn, HDR_BYTES, 16'd0, 1'b0));
            k = 0;
            while (k < WINDOW && slot_held[win_base[SLOT_W-1:0]]) begin
                s   = win_base[SLOT_W-1:0];
                off = (win_base == 16'd0) ? HDR_BYTES + 9'(held_name_len[s]) : HDR_BYTES;
                new_replies.push_back(mk_reply(KIND_DELIVER, win_base, held_fin[s], off,
                                               held_len[s], 1'b0));
                slot_held[s] = 1'b0;
                win_base     = win_base + 16'd1;
                k++;
            end
            new_replies[new_replies.size() - 1].last = 1'b1;
        end else if (seq_gap >= 16'h8000) begin
            new_replies.push_back(mk_reply(KIND_ACK, sq, fn, HDR_BYTES, 16'd0, 1'b1));
        end
    endtask

    function automatic t_hdr next_segment();
        t_hdr        h;
        int          pick;
        logic [15:0] sq;
        logic [15:0] len;
        logic        fn;
        pick = $urandom_range(0, 99);
        fn   = ($urandom_range(0, 3) == 0);
        len  = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 1500)) : 16'($urandom);
        if (pick < 45) begin
            sq = win_base + 16'($urandom_range(0, 3));
        end else if (pick < 70) begin
            sq = win_base + 16'($urandom_range(0, WINDOW - 1));
        end else if (pick < 78) begin
            if ($urandom_range(0, 1) == 0) sq = win_base - 16'($urandom_range(1, 64));
            else sq = win_base + 16'h8000 + 16'($urandom_range(0, 16'h7FFF));
        end else if (pick < 85) begin
            sq = win_base + 16'($urandom_range(WINDOW, 16'h7FFF));
        end else begin
            sq = win_base + 16'($urandom_range(0, WINDOW - 1));
        end
        h = segment_hdr(sq, 8'($urandom), fn, (pick >= 85 && pick < 89), len);
        if (pick >= 89 && pick < 95) begin
            h.hdr_ctrl[31:16] = h.hdr_ctrl[31:16] ^ 16'($urandom_range(1, 16'hFFFF));
        end else if (pick >= 95) begin
            h.hdr_ports  = $urandom;
            h.hdr_seq    = $urandom;
            h.hdr_ack    = $urandom;
            h.hdr_ctrl   = $urandom;
            h.hdr_length = $urandom;
        end
        return h;
    endfunction

    task automatic add_row(input t_hdr h, input int n, input t_res w0, input t_res w1);
        t_stim_row row;
        row.hdr     = h;
        row.n_typed = n;
        row.want0   = w0;
        row.want1   = w1;
        stim_table.push_back(row);
    endtask

    task automatic note_failure(input string what, input t_res want, input t_res got);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%s: expected kind=%0d seq=%h fin=%b off=%0d len=%h last=%b",
                     what, want.kind, want.seq_value, want.fin_flag, want.data_offset,
                     want.data_length, want.last);
            $display("    got kind=%0d seq=%h fin=%b off=%0d len=%h last=%b",
                     got.kind, got.seq_value, got.fin_flag, got.data_offset,
                     got.data_length, got.last);
        end
    endtask

    always @(posedge i_clk) begin : check_replies
        t_res want;
        logic bad;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_replies.size() == 0) begin
                note_failure("unexpected transfer", '0, o_res);
            end else begin
                want = pending_replies.pop_front();
                bad  = (o_res.kind        !== want.kind)        ||
                       (o_res.seq_value   !== want.seq_value)   ||
                       (o_res.fin_flag    !== want.fin_flag)    ||
                       (o_res.data_offset !== want.data_offset) ||
                       (o_res.data_length !== want.data_length) ||
                       (o_res.last        !== want.last);
                if (bad) note_failure("reply mismatch", want, o_res);
            end
        end
    end

    task automatic send_hdr(input t_hdr h);
        start <= 1'b1;
        i_hdr <= h;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 4)
                                                     : $urandom_range(5, 30);
            if (gap > 0) begin
                start <= 1'b0;
                i_hdr <= {$urandom, $urandom, $urandom, $urandom, $urandom};
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(negedge i_clk); while (pending_replies.size() != 0);
        @(posedge i_clk);
    endtask

    initial begin : stimulus
        t_hdr h;
        t_res none;
        int   i;
        none     = '0;
        win_base = '0;
        for (i = 0; i < WINDOW; i++) slot_held[i] = 1'b0;

        add_row('0, 0, none, none);
        add_row(segment_hdr(16'($urandom), 8'($urandom), 1'b1, 1'b1, 16'($urandom)), 1,
                mk_reply(KIND_SYNACK, 16'd0, 1'b0, HDR_BYTES, 16'd0, 1'b1), none);
        add_row(segment_hdr(16'd0, 8'hFF, 1'b0, 1'b0, 16'hFFFF), 2,
                mk_reply(KIND_ACK, 16'd0, 1'b0, HDR_BYTES, 16'd0, 1'b0),
                mk_reply(KIND_DELIVER, 16'd0, 1'b0, 9'd275, 16'hFFFF, 1'b1));
        for (i = 2; i <= WINDOW; i++) begin
            add_row(segment_hdr(16'(i), 8'($urandom), (i == WINDOW), 1'b0, 16'($urandom)),
                    -1, none, none);
        end
        add_row(segment_hdr(16'd5, 8'h00, 1'b1, 1'b0, 16'h0000), -1, none, none);
        add_row(segment_hdr(16'd1, 8'h00, 1'b0, 1'b0, 16'h0000), -1, none, none);
        add_row(segment_hdr(16'(2*WINDOW + 1), 8'h00, 1'b0, 1'b0, 16'd0), 0, none, none);
        add_row(segment_hdr(16'(WINDOW + 1 + 16'h7FFF), 8'h00, 1'b0, 1'b0, 16'd0), 0,
                none, none);
        add_row(segment_hdr(16'(WINDOW + 1 + 16'h8000), 8'h00, 1'b1, 1'b0, 16'd0), 1,
                mk_reply(KIND_ACK, 16'(WINDOW + 1 + 16'h8000), 1'b1, HDR_BYTES, 16'd0, 1'b1),
                none);
        h = segment_hdr(16'd0, 8'h00, 1'b0, 1'b0, 16'd0);
        h.hdr_ctrl[16] = ~h.hdr_ctrl[16];
        add_row(h, 0, none, none);
        add_row('1, 1, mk_reply(KIND_SYNACK, 16'd0, 1'b0, HDR_BYTES, 16'd0, 1'b1), none);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_table[r]) begin
            send_hdr(stim_table[r].hdr);
            predict_replies(stim_table[r].hdr);
            if (stim_table[r].n_typed < 0) begin
                foreach (new_replies[j]) pending_replies.push_back(new_replies[j]);
            end else begin
                if (stim_table[r].n_typed >= 1) pending_replies.push_back(stim_table[r].want0);
                if (stim_table[r].n_typed >= 2) pending_replies.push_back(stim_table[r].want1);
            end
            pace();
        end
        wait_drained();

        for (i = 0; i < RAND_ITEMS; i++) begin
            h = next_segment();
            send_hdr(h);
            predict_replies(h);
            foreach (new_replies[j]) pending_replies.push_back(new_replies[j]);
            if ($urandom_range(0, 39) == 0) wait_drained();
            else pace();
        end

        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (pending_replies.size() != 0) begin
            fail_count += pending_replies.size();
            $display("%0d replies never arrived", pending_replies.size());
        end
        if (fail_count == 0) begin
            $display("** selective_repeat_receiver: PASSED **");
        end else begin
            $display("** selective_repeat_receiver: FAILED **");
        end
        $finish;
    end

endmodule

// ===== selective_repeat_receiver.f =====
rtl/core/srr_pkg.sv
rtl/core/srr_ctrl.sv
rtl/core/srr_datapath.sv
rtl/core/selective_repeat_receiver.sv
tb/sv/tb_selective_repeat_receiver.sv
